// ===== rtl/cvg_pkg.sv =====
// Shared types and constants for the cylinder vertex generator.
// No dependencies; the divider, sine lane, sequencer, top level and bench refer to it by scoped names.
package cvg_pkg;

    localparam int MAX_SIDES = 4096;
    localparam int N_W       = 13;              // side count / edge index width
    localparam int IDX_W     = 12;              // side index width
    localparam int PHASE_W   = 16;              // 65536 phase units per turn
    localparam int NUM_W     = N_W + PHASE_W;   // dividend width of the phase divide
    localparam int DIV_STEPS = NUM_W;           // one quotient bit per stage
    localparam int SIN_LAT   = 8;               // stages of one sine lane
    localparam int PIPE_LAT  = DIV_STEPS + SIN_LAT;
    localparam int CFG_W     = 16;
    localparam int CFG_AW    = 2;
    localparam int POS_W     = 17;
    localparam int NORM_W    = 16;
    localparam int CNT_W     = 4;

    // Register indexes
    localparam logic [CFG_AW-1:0] CFG_HEIGHT = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_RADIUS = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_SIDES  = 2'd2;

    localparam logic [CFG_W-1:0] HEIGHT_RST = 16'd512;
    localparam logic [CFG_W-1:0] RADIUS_RST = 16'd256;
    localparam logic [N_W-1:0]   SIDES_RST  = 13'd1024;

    localparam logic [N_W-1:0]  SIDES_MAX = N_W'(MAX_SIDES);
    localparam logic [N_W-1:0]  SIDES_MIN = 13'd1;

    localparam logic signed [NORM_W-1:0] Q14_ONE  = 16'sd16384;
    localparam logic signed [NORM_W-1:0] Q14_MONE = -16'sd16384;
    localparam logic [PHASE_W-1:0]       QUARTER  = 16'd16384;

    // Q30 Taylor coefficients of sin(pi/2 x)
    localparam logic [30:0] C1 = 31'd1686629713;
    localparam logic [30:0] C3 = 31'd693598668;
    localparam logic [30:0] C5 = 31'd85569306;
    localparam logic [30:0] C7 = 31'd5026995;
    localparam logic [30:0] C9 = 31'd172272;

    localparam logic [CNT_W-1:0] VTX_LAST = 4'd11;

    typedef struct packed {
        logic signed [POS_W-1:0]  xa;
        logic signed [POS_W-1:0]  za;
        logic signed [POS_W-1:0]  xb;
        logic signed [POS_W-1:0]  zb;
        logic signed [NORM_W-1:0] sa;
        logic signed [NORM_W-1:0] ca;
        logic signed [NORM_W-1:0] sb;
        logic signed [NORM_W-1:0] cb;
    } t_slice;

    // One Horner step: c - round(p * x2 / 2^30)
    function automatic logic [30:0] horner_step(logic [30:0] c, logic [30:0] p,
                                                logic [30:0] x2);
        logic [61:0] prod;
        prod = 62'(p) * 62'(x2) + 62'(64'd1 << 29);
        return c - prod[60:30];
    endfunction

endpackage

// ===== rtl/cvg_phase_div.sv =====
// Pipelined restoring divider: phase = floor(k * 65536 / n) mod 65536.
// Depends on cvg_pkg.
module cvg_phase_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [cvg_pkg::N_W-1:0]       i_k,
    input  logic [cvg_pkg::N_W-1:0]       i_divisor,
    output logic [cvg_pkg::PHASE_W-1:0]   o_phase
);
    logic [cvg_pkg::N_W-1:0]     r_rem [cvg_pkg::DIV_STEPS];
    logic [cvg_pkg::NUM_W-1:0]   r_num [cvg_pkg::DIV_STEPS];
    logic [cvg_pkg::PHASE_W-1:0] r_q   [cvg_pkg::DIV_STEPS];

    genvar s;
    for (s = 0; s < cvg_pkg::DIV_STEPS; s++) begin : g_step
        logic [cvg_pkg::N_W-1:0]     w_rem;
        logic [cvg_pkg::NUM_W-1:0]   w_num;
        logic [cvg_pkg::PHASE_W-1:0] w_q;
        logic [cvg_pkg::N_W:0]       w_t;
        logic                        w_ge;

        if (s == 0) begin : g_first
            assign w_rem = '0;
            assign w_num = {i_k, {cvg_pkg::PHASE_W{1'b0}}};
            assign w_q   = '0;
        end else begin : g_next
            assign w_rem = r_rem[s-1];
            assign w_num = r_num[s-1];
            assign w_q   = r_q[s-1];
        end

        // shift in one dividend bit, subtract when it fits
        assign w_t  = {w_rem, w_num[cvg_pkg::NUM_W-1]};
        assign w_ge = w_t >= {1'b0, i_divisor};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? cvg_pkg::N_W'(w_t - {1'b0, i_divisor})
                                 : w_t[cvg_pkg::N_W-1:0];
                r_num[s] <= {w_num[cvg_pkg::NUM_W-2:0], 1'b0};
                r_q[s]   <= {w_q[cvg_pkg::PHASE_W-2:0], w_ge};
            end
        end
    end

    assign o_phase = r_q[cvg_pkg::DIV_STEPS-1];
endmodule

// ===== rtl/cvg_sine_lane.sv =====
// Sine of a 16-bit phase (Q1.14) and its radius-scaled position (Q8.8).
// Eight register stages; depends on cvg_pkg.
module cvg_sine_lane (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [cvg_pkg::PHASE_W-1:0]          i_phase,
    input  logic [15:0]                          i_radius,
    output logic signed [cvg_pkg::NORM_W-1:0]    o_sine,
    output logic signed [cvg_pkg::POS_W-1:0]     o_pos
);
    logic [14:0] r_u0, r_u1;
    logic        r_neg0, r_neg1;
    logic [30:0] r_x2_1;
    logic [30:0] r_p   [4];
    logic [30:0] r_x2h [3];
    logic [14:0] r_uh  [4];
    logic        r_negh[4];
    logic [14:0] r_mag;
    logic        r_neg6;
    logic signed [cvg_pkg::NORM_W-1:0] r_sin6, r_sin7;
    logic signed [cvg_pkg::POS_W-1:0]  r_pos7;

    logic [13:0] n_f;
    logic [45:0] n_prod6;
    logic [15:0] n_r6;
    logic [31:0] n_prod7;
    logic [15:0] n_m7;

    assign n_f     = i_phase[13:0];
    assign n_prod6 = 46'(r_p[3]) * 46'(r_uh[3]) + 46'(64'd1 << 29);
    assign n_r6    = n_prod6[45:30];
    assign n_prod7 = 32'(i_radius) * 32'(r_mag) + 32'd8192;
    assign n_m7    = n_prod7[29:14];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // fold into the first quadrant
            r_u0   <= i_phase[14] ? 15'(cvg_pkg::QUARTER - 16'(n_f)) : {1'b0, n_f};
            r_neg0 <= i_phase[15];
            // x squared in Q30
            r_x2_1 <= 31'((32'(r_u0) * 32'(r_u0)) << 2);
            r_u1   <= r_u0;
            r_neg1 <= r_neg0;
            // Horner chain
            r_p[0]    <= cvg_pkg::horner_step(cvg_pkg::C7, cvg_pkg::C9, r_x2_1);
            r_x2h[0]  <= r_x2_1;
            r_uh[0]   <= r_u1;
            r_negh[0] <= r_neg1;
            r_p[1]    <= cvg_pkg::horner_step(cvg_pkg::C5, r_p[0], r_x2h[0]);
            r_p[2]    <= cvg_pkg::horner_step(cvg_pkg::C3, r_p[1], r_x2h[1]);
            r_p[3]    <= cvg_pkg::horner_step(cvg_pkg::C1, r_p[2], r_x2h[2]);
            r_x2h[1]  <= r_x2h[0];
            r_x2h[2]  <= r_x2h[1];
            for (int k = 1; k < 4; k++) begin
                r_uh[k]   <= r_uh[k-1];
                r_negh[k] <= r_negh[k-1];
            end
            // final x multiply, clamp, sign
            r_mag  <= (n_r6 > 16'd16384) ? 15'd16384 : n_r6[14:0];
            r_neg6 <= r_negh[3];
            r_sin6 <= r_negh[3]
                ? -((n_r6 > 16'd16384) ? cvg_pkg::Q14_ONE : signed'(n_r6))
                :  ((n_r6 > 16'd16384) ? cvg_pkg::Q14_ONE : signed'(n_r6));
            // scale by radius, round half away from zero
            r_pos7 <= r_neg6 ? -signed'(17'(n_m7)) : signed'(17'(n_m7));
            r_sin7 <= r_sin6;
        end
    end

    assign o_sine = r_sin7;
    assign o_pos  = r_pos7;
endmodule

// ===== rtl/cvg_vertex_seq.sv =====
// Output stage: holds one finished slice and emits its twelve vertices.
// Depends on cvg_pkg.
module cvg_vertex_seq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  cvg_pkg::t_slice                    i_slice,
    input  logic [15:0]                        i_height,
    input  logic                               i_out_stall,
    output logic                               o_take,
    output logic                               o_out_valid,
    output logic signed [cvg_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [15:0]                 o_pos_y,
    output logic signed [cvg_pkg::POS_W-1:0]   o_pos_z,
    output logic signed [cvg_pkg::NORM_W-1:0]  o_norm_x,
    output logic signed [cvg_pkg::NORM_W-1:0]  o_norm_y,
    output logic signed [cvg_pkg::NORM_W-1:0]  o_norm_z,
    output logic                               o_vertex_last
);
    logic                    r_busy;
    logic [cvg_pkg::CNT_W-1:0] r_cnt;
    cvg_pkg::t_slice         r_slice;
    logic                    n_adv;
    logic                    n_last;
    logic signed [15:0]      n_top, n_bot;

    assign n_adv  = r_busy && !i_out_stall;
    assign n_last = r_cnt == cvg_pkg::VTX_LAST;
    assign o_take = !r_busy || (n_adv && n_last);
    assign n_top  = signed'({1'b0, i_height[15:1]});
    assign n_bot  = -n_top;

    // step through the slice; load a new one when idle or on the last vertex
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (n_adv && n_last) begin
            r_busy <= 1'b0;
        end else if (n_adv) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slice <= i_slice;
        end
    end

    assign o_out_valid   = r_busy;
    assign o_vertex_last = n_last;

    // vertex table: top fan, two body triangles, bottom fan
    always_comb begin
        o_pos_x  = '0;
        o_pos_y  = n_top;
        o_pos_z  = '0;
        o_norm_x = '0;
        o_norm_y = cvg_pkg::Q14_ONE;
        o_norm_z = '0;
        case (r_cnt)
            4'd1: begin
                o_pos_x = r_slice.xa; o_pos_z = r_slice.za;
            end
            4'd2: begin
                o_pos_x = r_slice.xb; o_pos_z = r_slice.zb;
            end
            4'd3, 4'd7: begin
                o_pos_x = r_slice.xb; o_pos_z = r_slice.zb;
                o_norm_x = r_slice.sb; o_norm_y = '0; o_norm_z = r_slice.cb;
            end
            4'd4: begin
                o_pos_x = r_slice.xa; o_pos_z = r_slice.za;
                o_norm_x = r_slice.sa; o_norm_y = '0; o_norm_z = r_slice.ca;
            end
            4'd5, 4'd8: begin
                o_pos_x = r_slice.xa; o_pos_y = n_bot; o_pos_z = r_slice.za;
                o_norm_x = r_slice.sa; o_norm_y = '0; o_norm_z = r_slice.ca;
            end
            4'd6: begin
                o_pos_x = r_slice.xb; o_pos_y = n_bot; o_pos_z = r_slice.zb;
                o_norm_x = r_slice.sb; o_norm_y = '0; o_norm_z = r_slice.cb;
            end
            4'd9: begin
                o_pos_y = n_bot; o_norm_y = cvg_pkg::Q14_MONE;
            end
            4'd10: begin
                o_pos_x = r_slice.xb; o_pos_y = n_bot; o_pos_z = r_slice.zb;
                o_norm_y = cvg_pkg::Q14_MONE;
            end
            4'd11: begin
                o_pos_x = r_slice.xa; o_pos_y = n_bot; o_pos_z = r_slice.za;
                o_norm_y = cvg_pkg::Q14_MONE;
            end
            default: begin
                o_pos_y = n_top;
            end
        endcase
    end
endmodule

// ===== rtl/cylinder_vertex_generator.sv =====
// Top level of the cylinder vertex generator: registers, phase dividers,
// sine lanes and vertex sequencer. Depends on cvg_pkg and the cvg_* modules.
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    i_side_index
//  out       output     o_out_valid / i_out_stall  o_pos_*, o_norm_*, o_vertex_last
//  cfg       input      i_cfg_we                   i_cfg_addr, i_cfg_wdata
//
// Each item gives twelve vertices, one per cycle while i_out_stall is low;
// the sequencer takes the next slice only on the last vertex or when idle.
// From intake to the first vertex an item passes 29 divider stages, 8 sine
// stages and the output register.
// The pipeline stalls as a whole when its last stage holds a slice that the
// sequencer cannot take. Reset is synchronous; it restores the registers and
// clears the valid bits and the sequencer, not the datapath.
module cylinder_vertex_generator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cvg_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  logic [cvg_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [cvg_pkg::IDX_W-1:0]          i_side_index,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [cvg_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [15:0]                 o_pos_y,
    output logic signed [cvg_pkg::POS_W-1:0]   o_pos_z,
    output logic signed [cvg_pkg::NORM_W-1:0]  o_norm_x,
    output logic signed [cvg_pkg::NORM_W-1:0]  o_norm_y,
    output logic signed [cvg_pkg::NORM_W-1:0]  o_norm_z,
    output logic                               o_vertex_last
);
    logic [15:0]               r_height;
    logic [15:0]               r_radius;
    logic [cvg_pkg::N_W-1:0]   r_sides;
    logic [cvg_pkg::PIPE_LAT-1:0] r_vld;

    logic [cvg_pkg::N_W-1:0]     n_div;
    logic                        n_en;
    logic                        n_take;
    logic                        n_load;
    logic [cvg_pkg::N_W-1:0]     n_ka, n_kb;
    logic [cvg_pkg::PHASE_W-1:0] n_pa, n_pb;
    cvg_pkg::t_slice             n_slice;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= cvg_pkg::HEIGHT_RST;
            r_radius <= cvg_pkg::RADIUS_RST;
            r_sides  <= cvg_pkg::SIDES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                cvg_pkg::CFG_HEIGHT: r_height <= i_cfg_wdata;
                cvg_pkg::CFG_RADIUS: r_radius <= i_cfg_wdata;
                cvg_pkg::CFG_SIDES:  r_sides  <= i_cfg_wdata[cvg_pkg::N_W-1:0];
                default: ;
            endcase
        end
    end

    // zero count acts as one, counts above the limit saturate
    assign n_div = (r_sides == '0) ? cvg_pkg::SIDES_MIN
                 : (r_sides > cvg_pkg::SIDES_MAX) ? cvg_pkg::SIDES_MAX : r_sides;

    assign n_en       = !r_vld[cvg_pkg::PIPE_LAT-1] || n_take;
    assign n_load     = r_vld[cvg_pkg::PIPE_LAT-1] && n_take;
    assign o_in_stall = !n_en;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[cvg_pkg::PIPE_LAT-2:0], i_in_valid};
        end
    end

    assign n_ka = cvg_pkg::N_W'(i_side_index);
    assign n_kb = cvg_pkg::N_W'(i_side_index) + 1'b1;

    cvg_phase_div u_div_a (
        .i_clk(i_clk), .i_en(n_en), .i_k(n_ka), .i_divisor(n_div), .o_phase(n_pa)
    );
    cvg_phase_div u_div_b (
        .i_clk(i_clk), .i_en(n_en), .i_k(n_kb), .i_divisor(n_div), .o_phase(n_pb)
    );

    cvg_sine_lane u_sin_a (
        .i_clk(i_clk), .i_en(n_en), .i_phase(n_pa), .i_radius(r_radius),
        .o_sine(n_slice.sa), .o_pos(n_slice.xa)
    );
    cvg_sine_lane u_cos_a (
        .i_clk(i_clk), .i_en(n_en), .i_phase(n_pa + cvg_pkg::QUARTER),
        .i_radius(r_radius), .o_sine(n_slice.ca), .o_pos(n_slice.za)
    );
    cvg_sine_lane u_sin_b (
        .i_clk(i_clk), .i_en(n_en), .i_phase(n_pb), .i_radius(r_radius),
        .o_sine(n_slice.sb), .o_pos(n_slice.xb)
    );
    cvg_sine_lane u_cos_b (
        .i_clk(i_clk), .i_en(n_en), .i_phase(n_pb + cvg_pkg::QUARTER),
        .i_radius(r_radius), .o_sine(n_slice.cb), .o_pos(n_slice.zb)
    );

    cvg_vertex_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(n_load), .i_slice(n_slice),
        .i_height(r_height), .i_out_stall(i_out_stall), .o_take(n_take),
        .o_out_valid(o_out_valid), .o_pos_x(o_pos_x), .o_pos_y(o_pos_y),
        .o_pos_z(o_pos_z), .o_norm_x(o_norm_x), .o_norm_y(o_norm_y),
        .o_norm_z(o_norm_z), .o_vertex_last(o_vertex_last)
    );
endmodule

// ===== rtl/cvg_checker.sv =====
// Port-level checks for the cylinder vertex generator, bound to the top.
// Depends on cylinder_vertex_generator only through its ports.
module cvg_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  logic               o_vertex_last,
    input  logic signed [16:0] o_pos_x,
    input  logic signed [15:0] o_norm_y
);
    // after reset no vertex is offered
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("vertex offered right after reset");

    // a slice continues until its last vertex
    a_slice_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_vertex_last && !i_out_stall |=> o_out_valid)
        else $error("slice ended before its last vertex");

    // the vertex after a last one starts a new slice
    a_last_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_vertex_last && !i_out_stall
        |=> !(o_out_valid && o_vertex_last))
        else $error("two last vertices in a row");

    // the last vertex belongs to the bottom fan
    a_last_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_vertex_last |-> o_norm_y == -16'sd16384)
        else $error("last vertex does not face down");

    // hold a stalled vertex
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pos_x))
        else $error("stalled vertex changed");
endmodule

bind cylinder_vertex_generator cvg_checker u_cvg_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_vertex_last(o_vertex_last),
    .o_pos_x(o_pos_x), .o_norm_y(o_norm_y)
);

// ===== bench/cylinder_vertex_generator_tb.sv =====
// Self-checking bench for the cylinder vertex generator: drives side
// indexes, predicts the twelve vertices of each slice and compares them.
// Depends on cvg_pkg and the cylinder_vertex_generator RTL.
`timescale 1ns / 100ps

module cylinder_vertex_generator_tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic signed [cvg_pkg::POS_W-1:0]  px;
        logic signed [15:0]                py;
        logic signed [cvg_pkg::POS_W-1:0]  pz;
        logic signed [cvg_pkg::NORM_W-1:0] nx;
        logic signed [cvg_pkg::NORM_W-1:0] ny;
        logic signed [cvg_pkg::NORM_W-1:0] nz;
        logic                              last;
    } t_vertex;

    // directed row: index, and optionally a known first edge-i vertex
    typedef struct {
        logic [cvg_pkg::IDX_W-1:0]        idx;
        bit                               known;
        logic signed [cvg_pkg::POS_W-1:0] ex;
        logic signed [cvg_pkg::POS_W-1:0] ez;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [cvg_pkg::CFG_AW-1:0] i_cfg_addr = cvg_pkg::CFG_HEIGHT;
    logic [cvg_pkg::CFG_W-1:0]  i_cfg_wdata = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [cvg_pkg::IDX_W-1:0]  i_side_index = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [cvg_pkg::POS_W-1:0]  o_pos_x, o_pos_z;
    logic signed [15:0]                o_pos_y;
    logic signed [cvg_pkg::NORM_W-1:0] o_norm_x, o_norm_y, o_norm_z;
    logic                 o_vertex_last;

    logic [15:0] height_q = cvg_pkg::HEIGHT_RST;
    logic [15:0] radius_q = cvg_pkg::RADIUS_RST;
    logic [12:0] sides_q  = cvg_pkg::SIDES_RST;

    t_vertex vertex_q[$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    cylinder_vertex_generator u_dut (.*);

    always #5 i_clk = ~i_clk;

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("cylinder_vertex_generator test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Q30 multiply with round-half-up shift, as used by each Horner step
    function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic int quarter_wave(int unsigned u);
        longint unsigned x2, acc, r;
        x2 = longint'(u) * u * 4;
        acc = 64'd172272;
        acc = 64'd5026995 - q30_mul(acc, x2);
        acc = 64'd85569306 - q30_mul(acc, x2);
        acc = 64'd693598668 - q30_mul(acc, x2);
        acc = 64'd1686629713 - q30_mul(acc, x2);
        r = (acc * u + (64'd1 << 29)) >> 30;
        if (r > 16384) r = 16384;
        return int'(r);
    endfunction

    function automatic int phase_to_sine(int unsigned ph);
        int unsigned q, f;
        int s;
        q = (ph >> 14) & 3;
        f = ph & 16383;
        s = quarter_wave(q[0] ? 16384 - f : f);
        return (q >= 2) ? -s : s;
    endfunction

    function automatic int unsigned edge_angle(int unsigned k, int unsigned n);
        longint unsigned r;
        r = k % n;
        return int'((r * 65536 / n) & 16'hFFFF);
    endfunction

    function automatic int radius_scale(int s);
        longint unsigned m;
        m = (longint'(radius_q) * (s < 0 ? -s : s) + 8192) >> 14;
        return (s < 0) ? -int'(m) : int'(m);
    endfunction

    // Queue the twelve expected vertices of one slice
    task automatic predict_slice(input logic [cvg_pkg::IDX_W-1:0] idx);
        int unsigned n, pa, pb;
        int sa, ca, sb, cb, xa, za, xb, zb, top, bot;
        int v[12][6];
        t_vertex e;
        n = sides_q;
        if (n == 0) n = 1;
        if (n > cvg_pkg::MAX_SIDES) n = cvg_pkg::MAX_SIDES;
        pa = edge_angle(32'(idx), n);
        pb = edge_angle(32'(idx) + 32'd1, n);
        sa = phase_to_sine(pa);
        ca = phase_to_sine((pa + 16384) & 16'hFFFF);
        sb = phase_to_sine(pb);
        cb = phase_to_sine((pb + 16384) & 16'hFFFF);
        xa = radius_scale(sa); za = radius_scale(ca);
        xb = radius_scale(sb); zb = radius_scale(cb);
        top = height_q >> 1;
        bot = -top;
        v = '{'{0, top, 0, 0, 16384, 0}, '{xa, top, za, 0, 16384, 0},
              '{xb, top, zb, 0, 16384, 0}, '{xb, top, zb, sb, 0, cb},
              '{xa, top, za, sa, 0, ca}, '{xa, bot, za, sa, 0, ca},
              '{xb, bot, zb, sb, 0, cb}, '{xb, top, zb, sb, 0, cb},
              '{xa, bot, za, sa, 0, ca}, '{0, bot, 0, 0, -16384, 0},
              '{xb, bot, zb, 0, -16384, 0}, '{xa, bot, za, 0, -16384, 0}};
        for (int k = 0; k < 12; k++) begin
            e.px = cvg_pkg::POS_W'(v[k][0]);
            e.py = 16'(v[k][1]);
            e.pz = cvg_pkg::POS_W'(v[k][2]);
            e.nx = cvg_pkg::NORM_W'(v[k][3]);
            e.ny = cvg_pkg::NORM_W'(v[k][4]);
            e.nz = cvg_pkg::NORM_W'(v[k][5]);
            e.last = (k == 11);
            vertex_q = {vertex_q, e};
        end
    endtask

    // Receiver: random stall, compare accepted vertices
    always @(posedge i_clk) begin
        t_vertex e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (vertex_q.size() == 0) begin
                report_mismatch("vertex with none expected");
            end else begin
                e = vertex_q.pop_front();
                if (o_pos_x !== e.px)
                    report_mismatch($sformatf("pos_x %0d exp %0d", o_pos_x, e.px));
                if (o_pos_y !== e.py)
                    report_mismatch($sformatf("pos_y %0d exp %0d", o_pos_y, e.py));
                if (o_pos_z !== e.pz)
                    report_mismatch($sformatf("pos_z %0d exp %0d", o_pos_z, e.pz));
                if (o_norm_x !== e.nx)
                    report_mismatch($sformatf("norm_x %0d exp %0d", o_norm_x, e.nx));
                if (o_norm_y !== e.ny)
                    report_mismatch($sformatf("norm_y %0d exp %0d", o_norm_y, e.ny));
                if (o_norm_z !== e.nz)
                    report_mismatch($sformatf("norm_z %0d exp %0d", o_norm_z, e.nz));
                if (o_vertex_last !== e.last)
                    report_mismatch("vertex_last");
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic write_reg(input logic [cvg_pkg::CFG_AW-1:0] addr,
                             input logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            cvg_pkg::CFG_HEIGHT: height_q = data;
            cvg_pkg::CFG_RADIUS: radius_q = data;
            default:             sides_q = data[12:0];
        endcase
    endtask

    // Send one index, idling randomly beforehand; valid held until accepted
    task automatic send_index(input logic [cvg_pkg::IDX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_side_index <= idx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_slice(idx);
    endtask

    task automatic drain_all();
        i_in_valid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(input int count);
        int unsigned lim;
        for (int j = 0; j < count; j++) begin
            lim = (sides_q > 4096) ? 4095 : ((sides_q == 0) ? 0 : sides_q - 1);
            if ($urandom_range(3) == 0)
                send_index(cvg_pkg::IDX_W'($urandom_range(4095)));
            else
                send_index(cvg_pkg::IDX_W'($urandom_range(lim)));
        end
    endtask

    t_row rows[] = '{
        '{12'd0,    1'b1, 17'sd0,   17'sd256},   // reset config, angle zero
        '{12'd256,  1'b1, 17'sd256, 17'sd0},     // quarter turn
        '{12'd512,  1'b1, 17'sd0,  -17'sd256},   // half turn
        '{12'd768,  1'b1, -17'sd256, 17'sd0},    // three quarters
        '{12'd1023, 1'b0, 17'sd0,   17'sd0},     // last slice wraps to edge zero
        '{12'd1024, 1'b1, 17'sd0,   17'sd256},   // index at count wraps
        '{12'd4095, 1'b0, 17'sd0,   17'sd0},     // index maximum
        '{12'd2730, 1'b0, 17'sd0,   17'sd0},
        '{12'd1365, 1'b0, 17'sd0,   17'sd0}
    };

    initial begin
        int base;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset config, then extremes of every register
        send_idle_pct = 33; recv_idle_pct = 56;
        foreach (rows[r]) begin
            send_index(rows[r].idx);
            // edge-i vertex of the slice just queued
            base = vertex_q.size() - 11;
            if (rows[r].known && (vertex_q[base].px !== rows[r].ex ||
                                  vertex_q[base].pz !== rows[r].ez))
                report_mismatch($sformatf("predictor disagrees on row %0d", r));
        end
        drain_all();
        write_reg(cvg_pkg::CFG_HEIGHT, 16'hFFFF);   // odd height truncates
        write_reg(cvg_pkg::CFG_RADIUS, 16'hFFFF);
        write_reg(cvg_pkg::CFG_SIDES, 16'd0);       // zero count acts as one
        send_index(12'd0); send_index(12'd4095);
        drain_all();
        write_reg(cvg_pkg::CFG_SIDES, 16'h1FFF);    // above maximum clamps
        write_reg(cvg_pkg::CFG_HEIGHT, 16'd0);
        write_reg(cvg_pkg::CFG_RADIUS, 16'd0);
        send_index(12'd0); send_index(12'd4095); send_index(12'd2048);
        drain_all();
        write_reg(cvg_pkg::CFG_SIDES, 16'd3);
        write_reg(cvg_pkg::CFG_RADIUS, 16'd1);
        write_reg(cvg_pkg::CFG_HEIGHT, 16'd1);
        send_index(12'd0); send_index(12'd2); send_index(12'd3);
        drain_all();

        // Random phases with shifting idle mix and configurations
        write_reg(cvg_pkg::CFG_SIDES, 16'($urandom_range(1, 4096)));
        write_reg(cvg_pkg::CFG_RADIUS, 16'($urandom));
        write_reg(cvg_pkg::CFG_HEIGHT, 16'($urandom));
        random_phase(40);
        drain_all();   // sender pauses until every vertex has come
        send_idle_pct = 56; recv_idle_pct = 33;
        write_reg(cvg_pkg::CFG_SIDES, 16'($urandom_range(1, 64)));
        write_reg(cvg_pkg::CFG_RADIUS, 16'($urandom));
        write_reg(cvg_pkg::CFG_HEIGHT, 16'($urandom));
        random_phase(40);
        drain_all();
        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(cvg_pkg::CFG_SIDES, 16'($urandom_range(0, 8191)));
        write_reg(cvg_pkg::CFG_RADIUS, 16'($urandom));
        write_reg(cvg_pkg::CFG_HEIGHT, 16'($urandom));
        random_phase(40);
        drain_all();

        if (error_count == 0)
            $display("cylinder_vertex_generator test passed");
        else
            $display("cylinder_vertex_generator test failed");
        $finish;
    end

endmodule

// ===== cylinder_vertex_generator.f =====
rtl/cvg_pkg.sv
rtl/cvg_phase_div.sv
rtl/cvg_sine_lane.sv
rtl/cvg_vertex_seq.sv
rtl/cylinder_vertex_generator.sv
rtl/cvg_checker.sv
bench/cylinder_vertex_generator_tb.sv
